[rtl/core/cmc_pkg.sv]
// Shared types, constants and helpers for the color math compositor.
// No dependencies; imported by cmc_pixel, color_math_compositor and the bench.
`default_nettype none

package cmc_pkg;

  localparam int unsigned ChW    = 5;
  localparam int unsigned ColorW = 3 * ChW;
  localparam int unsigned SrcW   = 3;
  localparam int unsigned LayerN = 7;
  localparam int unsigned LvlW   = 4;
  localparam int unsigned CfgW   = ColorW;

  localparam logic [SrcW-1:0]   SrcNoMath    = 3'd5;
  localparam logic [SrcW-1:0]   SrcBackdrop  = 3'd6;
  localparam logic [LvlW-1:0]   LvlFull      = 4'd15;

  // (2*l*c+15)/30 as a multiply by ceil(2^16/30); exact for inputs up to 945
  localparam int unsigned       ScaleShift   = 16;
  localparam logic [11:0]       ScaleRecip   = 12'd2185;
  localparam logic [9:0]        ScaleRound   = 10'd15;

  typedef enum logic [2:0] {
    CFG_COLOR_SUBTRACT = 3'd0,
    CFG_USE_SUBSCREEN  = 3'd1,
    CFG_LAYER_MATH     = 3'd2,
    CFG_HALVE_ENABLE   = 3'd3,
    CFG_FIXED_COLOR    = 3'd4,
    CFG_BRIGHTNESS     = 3'd5,
    CFG_HIRES          = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic              color_subtract;
    logic              use_subscreen;
    logic [LayerN-1:0] layer_math_enable;
    logic              halve_enable;
    logic [ColorW-1:0] fixed_color;
    logic [LvlW-1:0]   brightness;
    logic              hires;
  } cfg_t;

  function automatic logic [ChW-1:0] scale_ch(input logic [LvlW-1:0] lvl,
                                              input logic [ChW-1:0] ch);
    logic [8:0]  lc;
    logic [9:0]  x;
    logic [21:0] p;
    lc = {5'b0, lvl} * {4'b0, ch};
    x  = {lc, 1'b0} + ScaleRound;
    p  = {12'b0, x} * {10'b0, ScaleRecip};
    return p[ScaleShift+ChW-1:ScaleShift];
  endfunction

endpackage

`default_nettype wire

[rtl/core/color_math_compositor.sv]
// Color math compositor: input register, blend and brightness logic, result register.
// The input word is registered in the input stage, and its result words in the result stage once that is free.
// Throughput: one column per cycle while out_stall_i is low, but in hires mode two words per column,
// where the result register sends the sub-derived and then the main-derived word.
// Reset clears the pipeline valid bits and the config (brightness to full).
// Depends on cmc_pkg and cmc_pixel.
`default_nettype none

module color_math_compositor import cmc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [CfgW-1:0]   cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ColorW-1:0] main_rgb_i,
  input  wire logic [SrcW-1:0]   main_source_i,
  input  wire logic [ColorW-1:0] sub_rgb_i,
  input  wire logic [SrcW-1:0]   sub_source_i,
  input  wire logic              window_main_i,
  input  wire logic              window_sub_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [ColorW-1:0] out_pixel_o,
  output logic                   out_last_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{color_subtract: 1'b0, use_subscreen: 1'b0, layer_math_enable: '0,
                 halve_enable: 1'b0, fixed_color: '0, brightness: LvlFull,
                 hires: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COLOR_SUBTRACT: cfg_q.color_subtract    <= cfg_wdata_i[0];
        CFG_USE_SUBSCREEN:  cfg_q.use_subscreen     <= cfg_wdata_i[0];
        CFG_LAYER_MATH:     cfg_q.layer_math_enable <= cfg_wdata_i[LayerN-1:0];
        CFG_HALVE_ENABLE:   cfg_q.halve_enable      <= cfg_wdata_i[0];
        CFG_FIXED_COLOR:    cfg_q.fixed_color       <= cfg_wdata_i[ColorW-1:0];
        CFG_BRIGHTNESS:     cfg_q.brightness        <= cfg_wdata_i[LvlW-1:0];
        CFG_HIRES:          cfg_q.hires             <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input stage
  logic              s1_valid_q, s1_valid_d;
  logic [ColorW-1:0] s1_main_rgb_q, s1_sub_rgb_q;
  logic [SrcW-1:0]   s1_main_src_q, s1_sub_src_q;
  logic              s1_wm_q, s1_ws_q;

  // result stage
  logic              s2_valid_q, s2_valid_d;
  logic              s2_hires_q, s2_hires_d;
  logic              s2_phase_q, s2_phase_d;
  logic [ColorW-1:0] s2_pix_sub_q, s2_pix_main_q;

  logic [ColorW-1:0] pix_sub, pix_main;
  logic              in_fire, out_fire, s2_done, s2_free, s1_move, first_word;

  cmc_pixel u_pix_sub (
    .cfg_i         (cfg_q),
    .own_color_i   (s1_sub_rgb_q),
    .own_src_i     (s1_sub_src_q),
    .oth_color_i   (s1_main_rgb_q),
    .oth_src_i     (s1_main_src_q),
    .window_main_i (s1_wm_q),
    .window_sub_i  (s1_ws_q),
    .pixel_o       (pix_sub)
  );

  cmc_pixel u_pix_main (
    .cfg_i         (cfg_q),
    .own_color_i   (s1_main_rgb_q),
    .own_src_i     (s1_main_src_q),
    .oth_color_i   (s1_sub_rgb_q),
    .oth_src_i     (s1_sub_src_q),
    .window_main_i (s1_wm_q),
    .window_sub_i  (s1_ws_q),
    .pixel_o       (pix_main)
  );

  always_comb begin
    first_word  = s2_hires_q && !s2_phase_q;
    out_valid_o = s2_valid_q;
    out_pixel_o = first_word ? s2_pix_sub_q : s2_pix_main_q;
    out_last_o  = !first_word;
    out_fire    = s2_valid_q && !out_stall_i;
    s2_done     = out_fire && !first_word;
    s2_free     = !s2_valid_q || s2_done;
    s1_move     = s1_valid_q && s2_free;
    in_stall_o  = s1_valid_q && !s2_free;
    in_fire     = in_valid_i && !in_stall_o;
    s1_valid_d  = in_fire || (s1_valid_q && !s1_move);

    s2_valid_d = s2_valid_q;
    s2_hires_d = s2_hires_q;
    s2_phase_d = s2_phase_q;
    if (s1_move) begin
      s2_valid_d = 1'b1;
      s2_hires_d = cfg_q.hires;
      s2_phase_d = 1'b0;
    end else if (out_fire && first_word) begin
      s2_phase_d = 1'b1;
    end else if (s2_done) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_hires_q <= 1'b0;
      s2_phase_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      s2_hires_q <= s2_hires_d;
      s2_phase_q <= s2_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_main_rgb_q <= main_rgb_i;
      s1_main_src_q <= main_source_i;
      s1_sub_rgb_q  <= sub_rgb_i;
      s1_sub_src_q  <= sub_source_i;
      s1_wm_q       <= window_main_i;
      s1_ws_q       <= window_sub_i;
    end
    if (s1_move) begin
      s2_pix_sub_q  <= pix_sub;
      s2_pix_main_q <= pix_main;
    end
  end

endmodule

`default_nettype wire

[rtl/core/cmc_pixel.sv]
// One output pixel: operand select, windowing, add/subtract blend, brightness.
// Depends on cmc_pkg.
`default_nettype none

module cmc_pixel import cmc_pkg::*; (
  input  var cfg_t              cfg_i,
  input  wire logic [ColorW-1:0] own_color_i,
  input  wire logic [SrcW-1:0]   own_src_i,
  input  wire logic [ColorW-1:0] oth_color_i,
  input  wire logic [SrcW-1:0]   oth_src_i,
  input  wire logic              window_main_i,
  input  wire logic              window_sub_i,
  output logic      [ColorW-1:0] pixel_o
);

  logic [ColorW-1:0] oth;
  logic [SrcW-1:0]   oth_src;
  logic [ColorW-1:0] own;
  logic [LayerN:0]   layer_en;
  logic              math_on;
  logic              halve;
  logic [ColorW-1:0] blended;
  logic [ColorW-1:0] pre;

  always_comb begin
    oth      = cfg_i.use_subscreen ? oth_color_i : cfg_i.fixed_color;
    oth_src  = cfg_i.use_subscreen ? oth_src_i : SrcBackdrop;
    own      = window_main_i ? own_color_i : '0;
    layer_en = {1'b0, cfg_i.layer_math_enable};
    math_on  = (own_src_i != SrcNoMath) && layer_en[own_src_i] && window_sub_i;
    halve    = cfg_i.halve_enable && window_main_i &&
               (!cfg_i.use_subscreen || (oth_src != SrcBackdrop));
  end

  always_comb begin
    logic [ChW-1:0] ca;
    logic [ChW-1:0] cb;
    logic [ChW:0]   sum;
    logic [ChW-1:0] dif;
    blended = '0;
    for (int ch = 0; ch < 3; ch++) begin
      ca  = own[ch*ChW +: ChW];
      cb  = oth[ch*ChW +: ChW];
      sum = {1'b0, ca} + {1'b0, cb};
      dif = (ca > cb) ? (ca - cb) : '0;
      if (!cfg_i.color_subtract) begin
        if (halve) begin
          blended[ch*ChW +: ChW] = sum[ChW:1];
        end else begin
          blended[ch*ChW +: ChW] = sum[ChW] ? '1 : sum[ChW-1:0];
        end
      end else begin
        blended[ch*ChW +: ChW] = halve ? {1'b0, dif[ChW-1:1]} : dif;
      end
    end
  end

  always_comb begin
    if (!window_main_i && !window_sub_i) begin
      pre = '0;
    end else if (math_on) begin
      pre = blended;
    end else begin
      pre = own;
    end
    // red and blue trade places on the way out
    pixel_o = {scale_ch(cfg_i.brightness, pre[ChW-1:0]),
               scale_ch(cfg_i.brightness, pre[2*ChW-1:ChW]),
               scale_ch(cfg_i.brightness, pre[3*ChW-1:2*ChW])};
  end

endmodule

`default_nettype wire

[bench/color_math_compositor_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for color_math_compositor: blend, brightness and hires output words
// are predicted per column and compared in order. Depends on cmc_pkg and the compositor RTL.
module color_math_compositor_tb;
  import cmc_pkg::*;

  localparam logic [SrcW-1:0] SrcUnused = 3'd7;

  typedef struct packed {
    logic [ColorW-1:0] main_rgb;
    logic [SrcW-1:0]   main_source;
    logic [ColorW-1:0] sub_rgb;
    logic [SrcW-1:0]   sub_source;
    logic              window_main;
    logic              window_sub;
    logic              drain_first;
  } column_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel;
    logic              last;
  } pixel_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_index_i = CFG_COLOR_SUBTRACT;
  logic [CfgW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [ColorW-1:0] main_rgb_i = '0;
  logic [SrcW-1:0]   main_source_i = '0;
  logic [ColorW-1:0] sub_rgb_i = '0;
  logic [SrcW-1:0]   sub_source_i = '0;
  logic              window_main_i = 1'b0;
  logic              window_sub_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ColorW-1:0] out_pixel_o;
  logic              out_last_o;

  logic              mode_subtract = 1'b0;
  logic              mode_use_sub = 1'b0;
  logic [LayerN-1:0] mode_layers = '0;
  logic              mode_halve = 1'b0;
  logic [ColorW-1:0] mode_fixed = '0;
  logic [LvlW-1:0]   mode_level = LvlFull;
  logic              mode_hires = 1'b0;

  column_t     column_q[$];
  pixel_word_t due_pixels[$];
  column_t     cur_col;
  pixel_word_t want_word;
  int          cols_queued = 0;
  int          cols_accepted = 0;
  int          mismatches = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          send_gap = 0;
  int          stall_left = 0;

  color_math_compositor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .main_rgb_i    (main_rgb_i),
    .main_source_i (main_source_i),
    .sub_rgb_i     (sub_rgb_i),
    .sub_source_i  (sub_source_i),
    .window_main_i (window_main_i),
    .window_sub_i  (window_sub_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_pixel_o   (out_pixel_o),
    .out_last_o    (out_last_o)
  );

  function automatic logic [ColorW-1:0] blend_colors(input logic [ColorW-1:0] a,
                                                     input logic [ColorW-1:0] b,
                                                     input logic halve);
    logic [ColorW-1:0] res;
    int unsigned ca, cb, v;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      ca = 32'(a[k*ChW +: ChW]);
      cb = 32'(b[k*ChW +: ChW]);
      if (!mode_subtract) begin
        v = ca + cb;
        if (halve) v = v >> 1;
        else if (v > 31) v = 31;
      end else begin
        v = (ca > cb) ? ca - cb : 0;
        if (halve) v = v >> 1;
      end
      res[k*ChW +: ChW] = v[ChW-1:0];
    end
    return res;
  endfunction

  function automatic logic [ColorW-1:0] mix_pixel(input logic [ColorW-1:0] own,
                                                  input logic [SrcW-1:0] own_src,
                                                  input logic [ColorW-1:0] oth,
                                                  input logic [SrcW-1:0] oth_src,
                                                  input logic wm, input logic ws);
    logic [ColorW-1:0] mine, other;
    logic [SrcW-1:0]   other_src;
    logic              halve;
    mine = own;
    other = oth;
    other_src = oth_src;
    if (!mode_use_sub) begin
      other = mode_fixed;
      other_src = SrcBackdrop;
    end
    if (!wm && !ws) return '0;
    if (!wm) mine = '0;
    if (own_src != SrcNoMath && own_src != SrcUnused && mode_layers[own_src] && ws) begin
      halve = mode_halve && wm && (!mode_use_sub || other_src != SrcBackdrop);
      return blend_colors(mine, other, halve);
    end
    return mine;
  endfunction

  // channel order is reversed on the way out
  function automatic logic [ColorW-1:0] scale_pixel(input logic [ColorW-1:0] c);
    logic [ColorW-1:0] res;
    int unsigned ch, lv;
    lv = 32'(mode_level);
    res = '0;
    for (int k = 0; k < 3; k++) begin
      ch = 32'(c[k*ChW +: ChW]);
      ch = (2 * lv * ch + 15) / 30;
      res[(2-k)*ChW +: ChW] = ch[ChW-1:0];
    end
    return res;
  endfunction

  function automatic void predict_column(input column_t c);
    if (mode_hires)
      due_pixels.push_back(pixel_word_t'{scale_pixel(mix_pixel(c.sub_rgb, c.sub_source,
          c.main_rgb, c.main_source, c.window_main, c.window_sub)), 1'b0});
    due_pixels.push_back(pixel_word_t'{scale_pixel(mix_pixel(c.main_rgb, c.main_source,
        c.sub_rgb, c.sub_source, c.window_main, c.window_sub)), 1'b1});
  endfunction

  function automatic logic [ColorW-1:0] random_color();
    logic [ColorW-1:0] c;
    if ($urandom_range(0, 3) == 0) return ColorW'($urandom);
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0: c[k*ChW +: ChW] = '0;
        1: c[k*ChW +: ChW] = '1;
        default: c[k*ChW +: ChW] = ChW'($urandom_range(0, 31));
      endcase
    end
    return c;
  endfunction

  function automatic logic [SrcW-1:0] random_source();
    if ($urandom_range(0, 31) == 0) return SrcUnused;
    return SrcW'($urandom_range(0, 6));
  endfunction

  task automatic write_reg(input cfg_index_e idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_COLOR_SUBTRACT: mode_subtract = val[0];
      CFG_USE_SUBSCREEN:  mode_use_sub = val[0];
      CFG_LAYER_MATH:     mode_layers = val[LayerN-1:0];
      CFG_HALVE_ENABLE:   mode_halve = val[0];
      CFG_FIXED_COLOR:    mode_fixed = val;
      CFG_BRIGHTNESS:     mode_level = val[LvlW-1:0];
      CFG_HIRES:          mode_hires = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic subtract, input logic use_sub,
                           input logic [LayerN-1:0] layers, input logic halve,
                           input logic [ColorW-1:0] fixed, input logic [LvlW-1:0] level,
                           input logic hires);
    write_reg(CFG_COLOR_SUBTRACT, CfgW'(subtract));
    write_reg(CFG_USE_SUBSCREEN, CfgW'(use_sub));
    write_reg(CFG_LAYER_MATH, CfgW'(layers));
    write_reg(CFG_HALVE_ENABLE, CfgW'(halve));
    write_reg(CFG_FIXED_COLOR, fixed);
    write_reg(CFG_BRIGHTNESS, CfgW'(level));
    write_reg(CFG_HIRES, CfgW'(hires));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_column(input column_t c);
    column_q.push_back(c);
    cols_queued++;
  endtask

  task automatic settle();
    while (cols_accepted != cols_queued || due_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("color_math_compositor: mismatch");
    $finish;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_column(cur_col);
        cols_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (column_q.size() == 0 ||
                     (column_q[0].drain_first && due_pixels.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
          send_gap = $urandom_range(0, 15);
          in_valid_i <= 1'b0;
        end else begin
          cur_col = column_q.pop_front();
          in_valid_i <= 1'b1;
          main_rgb_i <= cur_col.main_rgb;
          main_source_i <= cur_col.main_source;
          sub_rgb_i <= cur_col.sub_rgb;
          sub_source_i <= cur_col.sub_source;
          window_main_i <= cur_col.window_main;
          window_sub_i <= cur_col.window_sub;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: pixel %h last %b", out_pixel_o, out_last_o);
        end else begin
          want_word = due_pixels.pop_front();
          if (out_pixel_o !== want_word.pixel || out_last_o !== want_word.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: expected pixel %h last %b, got pixel %h last %b",
                       want_word.pixel, want_word.last, out_pixel_o, out_last_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (recv_idle > 0 && $urandom_range(0, 99) < recv_idle) begin
        stall_left = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    column_t           col;
    logic [LayerN-1:0] lm;
    logic [ColorW-1:0] fc;
    logic [LvlW-1:0]   br;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 20;
    recv_idle = 20;

    // reset settings: plain pass-through, channel swap
    queue_column(column_t'{15'h7fff, 3'd0, 15'h0000, 3'd1, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h7c00, 3'd2, 15'h03ff, 3'd3, 1'b1, 1'b1, 1'b0});
    settle();

    // add with sub screen, halving, hires
    configure(1'b0, 1'b1, 7'h7f, 1'b1, 15'h7fff, LvlFull, 1'b1);
    queue_column(column_t'{15'h7fff, 3'd0, 15'h7fff, 3'd1, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h4210, 3'd2, 15'h7bde, SrcBackdrop, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h1234, SrcNoMath, 15'h5678, SrcUnused, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h7fff, 3'd3, 15'h7fff, 3'd4, 1'b0, 1'b0, 1'b0});
    queue_column(column_t'{15'h7fff, 3'd3, 15'h0421, 3'd4, 1'b0, 1'b1, 1'b0});
    queue_column(column_t'{15'h0421, 3'd4, 15'h7fff, 3'd0, 1'b1, 1'b0, 1'b0});
    queue_column(column_t'{15'h0000, SrcBackdrop, 15'h7fff, 3'd3, 1'b1, 1'b1, 1'b0});
    settle();

    // subtract against the fixed color, some layers off
    configure(1'b1, 1'b0, 7'h55, 1'b1, 15'h3def, 4'd7, 1'b0);
    queue_column(column_t'{15'h7fff, 3'd0, 15'h0000, 3'd1, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h7fff, 3'd1, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h0421, 3'd4, 15'h7fff, 3'd2, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h7bde, SrcBackdrop, 15'h1111, 3'd2, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h7fff, SrcNoMath, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h7fff, 3'd2, 15'h7fff, 3'd2, 1'b0, 1'b1, 1'b0});
    settle();

    // zero brightness, hires, no halving
    configure(1'b1, 1'b1, 7'h7f, 1'b0, 15'h0000, 4'd0, 1'b1);
    queue_column(column_t'{15'h7fff, 3'd0, 15'h0000, 3'd1, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h7fff, 3'd6, 15'h7fff, 3'd5, 1'b1, 1'b0, 1'b0});
    queue_column(column_t'{15'h2a55, 3'd3, 15'h55aa, 3'd4, 1'b0, 1'b1, 1'b0});
    settle();

    // mid brightness, add fixed color without halving
    configure(1'b0, 1'b0, 7'h7f, 1'b0, 15'h7fff, 4'd8, 1'b0);
    queue_column(column_t'{15'h0000, 3'd0, 15'h7fff, 3'd1, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h5294, 3'd6, 15'h0000, 3'd6, 1'b1, 1'b1, 1'b0});
    queue_column(column_t'{15'h7fff, SrcUnused, 15'h0000, 3'd0, 1'b1, 1'b1, 1'b0});
    settle();

    for (int p = 0; p < 10; p++) begin
      lm = (p % 3 == 0) ? 7'h7f : ((p == 4) ? 7'h00 : LayerN'($urandom));
      fc = (p == 1) ? 15'h7fff : ((p == 2) ? 15'h0000 : random_color());
      br = (p % 4 == 0) ? LvlFull : ((p == 5) ? 4'd0 : LvlW'($urandom_range(1, 14)));
      configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), lm,
                1'($urandom_range(0, 1)), fc, br, 1'(p % 2));
      send_idle = (p >= 8) ? 0 : 15 * $urandom_range(0, 2);
      recv_idle = (p >= 8) ? 0 : 15 * $urandom_range(0, 2);
      for (int i = 0; i < 165; i++) begin
        col.main_rgb = random_color();
        col.main_source = random_source();
        col.sub_rgb = random_color();
        col.sub_source = random_source();
        col.window_main = 1'($urandom_range(0, 1));
        col.window_sub = 1'($urandom_range(0, 1));
        col.drain_first = (i == 80 && p < 8);
        queue_column(col);
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && due_pixels.size() == 0) begin
      $display("color_math_compositor: match");
    end else begin
      $display("color_math_compositor: mismatch");
    end
    $finish;
  end

endmodule

[color_math_compositor.f]
rtl/core/cmc_pkg.sv
rtl/core/cmc_pixel.sv
rtl/core/color_math_compositor.sv
bench/color_math_compositor_tb.sv
